FILE: rtl/core/jpp_pkg.sv
package jpp_pkg;

   // Datapath widths follow from the 8-bit fields of the interface.
   localparam int SAMPLE_BITS = 8;
   localparam int NORM_SHIFT  = 16;
   localparam int QUO_BITS    = SAMPLE_BITS + NORM_SHIFT;
   localparam int NORM_BITS   = QUO_BITS + 1;
   localparam int CORD_BITS   = QUO_BITS + 3;
   localparam int ANGLE_BITS  = 32;
   localparam int PROD_BITS   = ANGLE_BITS + 7;
   localparam int FRAC_BITS   = 28;
   localparam int ROOT_BITS   = SAMPLE_BITS + 1;
   localparam int SQ_BITS     = 2 * ROOT_BITS;
   localparam int TABLE_LEN   = 24;

   localparam logic signed [ANGLE_BITS-1:0] PI_Q28      = 32'sd843314856;
   localparam logic signed [6:0]            ANGLE_SCALE = 7'sd57;
   localparam logic signed [10:0]           DEG_LIMIT   = 11'sd179;
   localparam logic [ROOT_BITS-1:0]         DIST_MAX    = ROOT_BITS'(511);

   typedef enum logic [2:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_MAX_X    = 3'd2,
      CSR_MAX_Y    = 3'd3,
      CSR_MIN_X    = 3'd4,
      CSR_MIN_Y    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0] x_sample;
      logic [7:0] y_sample;
   } req_type;

   typedef struct packed {
      logic signed [8:0] angle_deg;
      logic [8:0]        distance;
      logic              span_zero;
   } rsp_type;

   // atan(2^-i) in Q28 radians, rounded down.
   function automatic logic signed [ANGLE_BITS-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ANGLE_BITS-1:0] val;
      case (idx)
         5'd0:    val = 32'sd210828714;
         5'd1:    val = 32'sd124459457;
         5'd2:    val = 32'sd65760959;
         5'd3:    val = 32'sd33381289;
         5'd4:    val = 32'sd16755421;
         5'd5:    val = 32'sd8385878;
         5'd6:    val = 32'sd4193962;
         5'd7:    val = 32'sd2097109;
         5'd8:    val = 32'sd1048570;
         5'd9:    val = 32'sd524287;
         5'd10:   val = 32'sd262143;
         5'd11:   val = 32'sd131071;
         5'd12:   val = 32'sd65535;
         5'd13:   val = 32'sd32767;
         5'd14:   val = 32'sd16383;
         5'd15:   val = 32'sd8191;
         5'd16:   val = 32'sd4095;
         5'd17:   val = 32'sd2047;
         5'd18:   val = 32'sd1023;
         5'd19:   val = 32'sd511;
         5'd20:   val = 32'sd255;
         5'd21:   val = 32'sd127;
         5'd22:   val = 32'sd63;
         5'd23:   val = 32'sd31;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

FILE: rtl/core/jpp_div.sv
module jpp_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [jpp_pkg::SAMPLE_BITS-1:0] num,
   input  logic [jpp_pkg::SAMPLE_BITS-1:0] den,
   output logic [jpp_pkg::QUO_BITS-1:0]    quo
);
   import jpp_pkg::*;

   // Restoring division of num * 2^16 by den, one quotient bit per stage.
   logic [QUO_BITS-1:0]    dvd_ff [QUO_BITS];
   logic [SAMPLE_BITS-1:0] den_ff [QUO_BITS];
   logic [SAMPLE_BITS-1:0] rem_ff [QUO_BITS];
   logic [QUO_BITS-1:0]    quo_ff [QUO_BITS];

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
      logic [QUO_BITS-1:0]    dvd_prev;
      logic [SAMPLE_BITS-1:0] den_prev;
      logic [SAMPLE_BITS-1:0] rem_prev;
      logic [QUO_BITS-1:0]    quo_prev;
      logic [SAMPLE_BITS:0]   trial;
      logic [SAMPLE_BITS:0]   diff;
      logic                   ge;

      if (k == 0) begin : g_first
         assign dvd_prev = {num, {NORM_SHIFT{1'b0}}};
         assign den_prev = den;
         assign rem_prev = '0;
         assign quo_prev = '0;
      end else begin : g_next
         assign dvd_prev = dvd_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      assign trial = {rem_prev, dvd_prev[QUO_BITS-1-k]};
      assign ge    = trial >= {1'b0, den_prev};
      assign diff  = trial - {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            dvd_ff[k] <= dvd_prev;
            den_ff[k] <= den_prev;
            rem_ff[k] <= ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
            quo_ff[k] <= {quo_prev[QUO_BITS-2:0], ge};
         end
      end
   end

   assign quo = quo_ff[QUO_BITS-1];

endmodule

FILE: rtl/core/jpp_isqrt.sv
module jpp_isqrt (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [jpp_pkg::SAMPLE_BITS:0] dx,
   input  logic signed [jpp_pkg::SAMPLE_BITS:0] dy,
   output logic [jpp_pkg::ROOT_BITS-1:0]        root
);
   import jpp_pkg::*;

   localparam int REM_BITS = ROOT_BITS + 3;

   logic signed [SQ_BITS-1:0] sq_in;
   logic [SQ_BITS-1:0]        sq_ff;
   logic [SQ_BITS-1:0]        rad_ff  [ROOT_BITS];
   logic [REM_BITS-1:0]       rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0]      root_ff [ROOT_BITS];

   assign sq_in = SQ_BITS'(dx) * SQ_BITS'(dx) + SQ_BITS'(dy) * SQ_BITS'(dy);

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_in;
      end
   end

   // One result bit per stage, two radicand bits consumed each time.
   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
      logic [SQ_BITS-1:0]   rad_prev;
      logic [REM_BITS-1:0]  rem_prev;
      logic [ROOT_BITS-1:0] root_prev;
      logic [REM_BITS-1:0]  rem_sh;
      logic [REM_BITS-1:0]  trial;
      logic                 ge;

      if (k == 0) begin : g_first
         assign rad_prev  = sq_ff;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      assign rem_sh = {rem_prev[REM_BITS-3:0], rad_prev[SQ_BITS-1-2*k -: 2]};
      assign trial  = REM_BITS'({root_prev, 2'b01});
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_prev;
            rem_ff[k]  <= ge ? (rem_sh - trial) : rem_sh;
            root_ff[k] <= {root_prev[ROOT_BITS-2:0], ge};
         end
      end
   end

   assign root = root_ff[ROOT_BITS-1];

endmodule

FILE: rtl/core/jpp_cordic.sv
module jpp_cordic #(
   parameter int STAGES = 16
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [jpp_pkg::NORM_BITS-1:0] norm_x,
   input  logic signed [jpp_pkg::NORM_BITS-1:0] norm_y,
   output logic signed [8:0]                    deg
);
   import jpp_pkg::*;

   logic signed [CORD_BITS-1:0]  cx_ff [STAGES+1];
   logic signed [CORD_BITS-1:0]  cy_ff [STAGES+1];
   logic signed [ANGLE_BITS-1:0] cz_ff [STAGES+1];
   logic                         zf_ff [STAGES+2];

   logic signed [CORD_BITS-1:0]  x_ext;
   logic signed [CORD_BITS-1:0]  y_ext;
   logic signed [PROD_BITS-1:0]  prod_in;
   logic signed [PROD_BITS-1:0]  prod_ff;
   logic signed [PROD_BITS-1:0]  adj;
   logic signed [10:0]           whole;
   logic signed [8:0]            deg_in;
   logic signed [8:0]            deg_ff;

   assign x_ext = CORD_BITS'(norm_x);
   assign y_ext = CORD_BITS'(norm_y);

   // Left half plane is folded over by a half turn before the iterations.
   always_ff @(posedge clock) begin
      if (en) begin
         zf_ff[0] <= (norm_x == '0) && (norm_y == '0);
         if (norm_x < 0) begin
            cx_ff[0] <= -x_ext;
            cy_ff[0] <= -y_ext;
            cz_ff[0] <= (norm_y < 0) ? -PI_Q28 : PI_Q28;
         end else begin
            cx_ff[0] <= x_ext;
            cy_ff[0] <= y_ext;
            cz_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_iter
      logic signed [CORD_BITS-1:0]  xs;
      logic signed [CORD_BITS-1:0]  ys;
      logic signed [ANGLE_BITS-1:0] step;

      assign xs   = cx_ff[i] >>> i;
      assign ys   = cy_ff[i] >>> i;
      assign step = atan_entry(5'(i));

      always_ff @(posedge clock) begin
         if (en) begin
            zf_ff[i+1] <= zf_ff[i];
            if (!cy_ff[i][CORD_BITS-1]) begin
               cx_ff[i+1] <= cx_ff[i] + ys;
               cy_ff[i+1] <= cy_ff[i] - xs;
               cz_ff[i+1] <= cz_ff[i] + step;
            end else begin
               cx_ff[i+1] <= cx_ff[i] - ys;
               cy_ff[i+1] <= cy_ff[i] + xs;
               cz_ff[i+1] <= cz_ff[i] - step;
            end
         end
      end
   end

   assign prod_in = PROD_BITS'(cz_ff[STAGES]) * PROD_BITS'(ANGLE_SCALE);

   // Truncation toward zero: bias negative products before the shift.
   assign adj   = prod_ff + (prod_ff[PROD_BITS-1] ?
                  PROD_BITS'((64'd1 << FRAC_BITS) - 64'd1) : PROD_BITS'(0));
   assign whole = adj[FRAC_BITS+10:FRAC_BITS];

   always_comb begin
      if (zf_ff[STAGES+1]) begin
         deg_in = '0;
      end else if (whole > DEG_LIMIT) begin
         deg_in = 9'(DEG_LIMIT);
      end else if (whole < -DEG_LIMIT) begin
         deg_in = -9'(DEG_LIMIT);
      end else begin
         deg_in = whole[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff           <= prod_in;
         zf_ff[STAGES+1]   <= zf_ff[STAGES];
         deg_ff            <= deg_in;
      end
   end

   assign deg = deg_ff;

endmodule

FILE: rtl/core/joystick_polar_position.sv
// Joystick polar position.
// Each request transaction carries one X/Y sample pair; each response
// transaction carries the stick direction in whole degrees (-179..179), the
// integer distance from the calibrated centre and a flag raised when a
// calibration span on the used side was not positive and the axis saturated.
// Calibration is written through the csr_ port (index 0..5: center_x,
// center_y, max_x, max_y, min_x, min_y); write it only while the pipeline is
// empty. Writes to other indexes are dropped.
// Both channels use valid/ready. The block is one pipeline that accepts a new
// transaction every cycle unless the receiver stalls. Its stages are one input
// stage, 24 divider stages (one quotient bit each), one scaling stage, then
// the CORDIC with a fold stage, CORDIC_STAGES iterations, a multiply stage
// and a clamp stage. The square root runs alongside the divider and its
// result is delayed to line up.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req_ready drops; nothing is lost or repeated. Reset empties the
// pipeline and restores the calibration defaults.
module joystick_polar_position #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jpp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jpp_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_addr,
   input  logic [7:0]       csr_wdata
);
   import jpp_pkg::*;

   localparam int LATENCY  = QUO_BITS + CORDIC_STAGES + 5;
   localparam int FLAG_DLY = LATENCY;
   localparam int DIST_DLY = LATENCY - ROOT_BITS - 2;
   localparam int SB       = SAMPLE_BITS;

   typedef struct packed {
      logic neg;
      logic zero;
      logic sat;
   } axis_side_type;

   // Calibration registers.
   logic [7:0] center_x_ff, center_y_ff, max_x_ff, max_y_ff, min_x_ff, min_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= 8'd128;
         center_y_ff <= 8'd128;
         max_x_ff    <= 8'd255;
         max_y_ff    <= 8'd255;
         min_x_ff    <= 8'd0;
         min_y_ff    <= 8'd0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            CSR_MAX_X:    max_x_ff    <= csr_wdata;
            CSR_MAX_Y:    max_y_ff    <= csr_wdata;
            CSR_MIN_X:    min_x_ff    <= csr_wdata;
            CSR_MIN_Y:    min_y_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The pipeline moves as a whole unless a finished result is held up.
   logic vld_ff [LATENCY];
   logic en;

   assign en        = !vld_ff[LATENCY-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LATENCY; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < LATENCY; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Input stage: offsets, the span on the side each offset falls, and the
   // saturation cases.
   logic signed [SB:0] dx, dy, span_px, span_nx, span_py, span_ny, span_x, span_y;
   axis_side_type      side_x, side_y;

   assign dx      = $signed({1'b0, req_data.x_sample}) - $signed({1'b0, center_x_ff});
   assign dy      = $signed({1'b0, req_data.y_sample}) - $signed({1'b0, center_y_ff});
   assign span_px = $signed({1'b0, max_x_ff}) - $signed({1'b0, center_x_ff});
   assign span_nx = $signed({1'b0, center_x_ff}) - $signed({1'b0, min_x_ff});
   assign span_py = $signed({1'b0, max_y_ff}) - $signed({1'b0, center_y_ff});
   assign span_ny = $signed({1'b0, center_y_ff}) - $signed({1'b0, min_y_ff});
   assign span_x  = dx[SB] ? span_nx : span_px;
   assign span_y  = dy[SB] ? span_ny : span_py;

   assign side_x.neg  = dx[SB];
   assign side_x.zero = (dx == '0);
   assign side_x.sat  = (dx != '0) && (span_x <= 0);
   assign side_y.neg  = dy[SB];
   assign side_y.zero = (dy == '0);
   assign side_y.sat  = (dy != '0) && (span_y <= 0);

   logic signed [SB:0]   dx_ff, dy_ff;
   logic [SB-1:0]        ax_ff, ay_ff, sx_ff, sy_ff;
   axis_side_type        side_x_ff [QUO_BITS+1];
   axis_side_type        side_y_ff [QUO_BITS+1];
   logic                 flag_ff   [FLAG_DLY];

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff        <= dx;
         dy_ff        <= dy;
         ax_ff        <= dx[SB] ? SB'(-dx) : dx[SB-1:0];
         ay_ff        <= dy[SB] ? SB'(-dy) : dy[SB-1:0];
         sx_ff        <= span_x[SB-1:0];
         sy_ff        <= span_y[SB-1:0];
         side_x_ff[0] <= side_x;
         side_y_ff[0] <= side_y;
         flag_ff[0]   <= side_x.sat || side_y.sat;
         for (int k = 1; k <= QUO_BITS; k++) begin
            side_x_ff[k] <= side_x_ff[k-1];
            side_y_ff[k] <= side_y_ff[k-1];
         end
         for (int k = 1; k < FLAG_DLY; k++) begin
            flag_ff[k] <= flag_ff[k-1];
         end
      end
   end

   // Normalization: magnitude quotient, then sign and saturation.
   logic [QUO_BITS-1:0] qx, qy;

   jpp_div u_div_x (.clock(clock), .en(en), .num(ax_ff), .den(sx_ff), .quo(qx));
   jpp_div u_div_y (.clock(clock), .en(en), .num(ay_ff), .den(sy_ff), .quo(qy));

   function automatic logic signed [NORM_BITS-1:0] scale_axis(
      input axis_side_type     side,
      input logic [QUO_BITS-1:0] q
   );
      logic signed [NORM_BITS-1:0] mag;
      mag = side.sat ? NORM_BITS'(1 << NORM_SHIFT) : $signed({1'b0, q});
      if (side.zero) begin
         return '0;
      end
      return side.neg ? -mag : mag;
   endfunction

   logic signed [NORM_BITS-1:0] nx_ff, ny_ff;

   // The side information is delayed alongside the divider stages, so it is taken
   // at the depth where the quotient leaves the divider.
   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff <= scale_axis(side_x_ff[QUO_BITS], qx);
         ny_ff <= scale_axis(side_y_ff[QUO_BITS], qy);
      end
   end

   logic signed [8:0] deg;

   jpp_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clock  (clock),
      .en     (en),
      .norm_x (nx_ff),
      .norm_y (ny_ff),
      .deg    (deg)
   );

   // Distance runs on the raw offsets and waits for the angle.
   logic [ROOT_BITS-1:0] root;
   logic [8:0]           dist_ff [DIST_DLY];

   jpp_isqrt u_isqrt (.clock(clock), .en(en), .dx(dx_ff), .dy(dy_ff), .root(root));

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff[0] <= (root > DIST_MAX) ? 9'(DIST_MAX) : root[8:0];
         for (int k = 1; k < DIST_DLY; k++) begin
            dist_ff[k] <= dist_ff[k-1];
         end
      end
   end

   assign rsp_data.angle_deg = deg;
   assign rsp_data.distance  = dist_ff[DIST_DLY-1];
   assign rsp_data.span_zero = flag_ff[FLAG_DLY-1];

endmodule
